// ===== rtl/core/pbc_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for bbox centring
`timescale 1ns / 1ps
package pbc_pkg;

   localparam int COORD_W        = 8;
   localparam int WORD_W         = 2 * COORD_W;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [COORD_W-1:0] COORD_MAX = 8'd255;
   localparam logic [COORD_W-1:0] COORD_MIN = 8'd0;
   localparam logic signed [COORD_W:0] CENTRE = 9'sd128;

   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic signed [COORD_W:0]   offset_type;
   typedef logic signed [COORD_W+1:0] shifted_type;

   typedef struct packed {
      logic upd;
      logic clr;
   } bbox_ctrl_type;

   typedef struct packed {
      offset_type off_x;
      offset_type off_y;
   } bbox_off_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } rsp_word_type;

   // 128 minus floored midpoint of [lo, hi]
   function automatic offset_type axis_offset(input coord_type lo, input coord_type hi);
      logic [COORD_W:0]   sum;
      logic [COORD_W-1:0] mid;
      sum = {1'b0, lo} + {1'b0, hi};
      mid = sum[COORD_W:1];
      return CENTRE - $signed({1'b0, mid});
   endfunction

   function automatic coord_type shift_clamp(input coord_type p, input offset_type off);
      shifted_type s;
      s = $signed({2'b00, p}) + $signed({off[COORD_W], off});
      if (s < 0) begin
         return COORD_MIN;
      end else if (s > $signed({2'b00, COORD_MAX})) begin
         return COORD_MAX;
      end else begin
         return s[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/pbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module pbc_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pbc_bbox.sv =====
// Bounding-box tracker: running min/max per axis and centring offsets
`timescale 1ns / 1ps
module pbc_bbox (
   input  logic                  clock,
   input  logic                  reset,
   input  pbc_pkg::bbox_ctrl_type ctrl,
   input  pbc_pkg::coord_type    px,
   input  pbc_pkg::coord_type    py,
   output pbc_pkg::bbox_off_type offs
);
   import pbc_pkg::*;

   coord_type min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   coord_type min_x_in, max_x_in, min_y_in, max_y_in;

   always_comb begin
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (ctrl.clr) begin
         min_x_in = COORD_MAX;
         max_x_in = COORD_MIN;
         min_y_in = COORD_MAX;
         max_y_in = COORD_MIN;
      end else if (ctrl.upd) begin
         if (px < min_x_ff) min_x_in = px;
         if (px > max_x_ff) max_x_in = px;
         if (py < min_y_ff) min_y_in = py;
         if (py > max_y_ff) max_y_in = py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= COORD_MAX;
         max_x_ff <= COORD_MIN;
         min_y_ff <= COORD_MAX;
         max_y_ff <= COORD_MIN;
      end else begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

   assign offs.off_x = axis_offset(min_x_ff, max_x_ff);
   assign offs.off_y = axis_offset(min_y_ff, max_y_ff);

endmodule

// ===== rtl/core/point_set_bbox_centring.sv =====
// Top level: point-set bounding-box centring, store then replay
//
//   channel | dir | ports                                   | word
//   req     | in  | req_valid req_stall req_point_x/y/is_last | one point
//   rsp     | out | rsp_valid rsp_stall rsp_out_x/y/out_last  | one centred point
//
// Load: one point per cycle into the point RAM, bbox updated alongside.
// After the last point: the ST_CALC state latches the offsets, then replay at
// one word per cycle while rsp_stall allows, paced by the registered RAM read.
// req_stall is high from the cycle after the last point until the replay is done.
// Two-entry output queue absorbs rsp_stall without losing a RAM read.
// Synchronous reset; the RAM needs no clearing, only counted entries are read.
`timescale 1ns / 1ps
module point_set_bbox_centring #(
   parameter int MAX_POINTS = pbc_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pbc_pkg::coord_type req_point_x,
   input  pbc_pkg::coord_type req_point_y,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pbc_pkg::coord_type rsp_out_x,
   output pbc_pkg::coord_type rsp_out_y,
   output logic               rsp_out_last
);
   import pbc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             pend_last_ff, pend_last_in;
   logic [1:0]       occ_ff, occ_in;
   offset_type       off_x_ff, off_x_in, off_y_ff, off_y_in;
   rsp_word_type     q0_ff, q0_in, q1_ff, q1_in;

   logic             req_acc, store_en, pop, issue, done;
   logic [1:0]       occ_nxt, pos;
   logic [WORD_W-1:0] rd_data;
   rsp_word_type     arr;
   bbox_ctrl_type    bctrl;
   bbox_off_type     offs;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid & ~req_stall;
   assign store_en  = req_acc & (count_ff < CNT_W'(MAX_POINTS));

   assign rsp_valid = (occ_ff != 2'd0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign occ_nxt   = occ_ff + {1'b0, rd_pend_ff} - {1'b0, pop};
   assign issue     = (state_ff == ST_EMIT) && (rd_idx_ff < count_ff) && (occ_nxt < 2'd2);
   assign done      = (state_ff == ST_EMIT) && (rd_idx_ff == count_ff) && !rd_pend_ff
                      && (occ_ff == 2'd0);

   assign bctrl.upd = store_en;
   assign bctrl.clr = (state_ff == ST_CALC);

   pbc_bbox u_bbox (
      .clock (clock),
      .reset (reset),
      .ctrl  (bctrl),
      .px    (req_point_x),
      .py    (req_point_y),
      .offs  (offs)
   );

   pbc_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_point_y, req_point_x}),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign arr.x    = shift_clamp(rd_data[COORD_W-1:0], off_x_ff);
   assign arr.y    = shift_clamp(rd_data[WORD_W-1:COORD_W], off_y_ff);
   assign arr.last = pend_last_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      rd_pend_in   = issue;
      pend_last_in = (rd_idx_ff == count_ff - CNT_W'(1));
      if (store_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_is_last) state_in = ST_CALC;
         end
         ST_CALC: begin
            off_x_in  = offs.off_x;
            off_y_in  = offs.off_y;
            rd_idx_in = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (issue) rd_idx_in = rd_idx_ff + CNT_W'(1);
            if (done) begin
               state_in  = ST_LOAD;
               count_in  = '0;
               rd_idx_in = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // output queue: q0 is the head shown on rsp_*
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      occ_in = occ_nxt;
      pos    = occ_ff - {1'b0, pop};
      if (pop) q0_in = q1_ff;
      if (rd_pend_ff) begin
         if (pos == 2'd0) begin
            q0_in = arr;
         end else begin
            q1_in = arr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         rd_pend_ff <= 1'b0;
         occ_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         rd_pend_ff <= rd_pend_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      off_x_ff     <= off_x_in;
      off_y_ff     <= off_y_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
   end

   assign rsp_out_x    = q0_ff.x;
   assign rsp_out_y    = q0_ff.y;
   assign rsp_out_last = q0_ff.last;

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && occ_ff == 2'd2) |-> pop)
      else $error("read data arrives with output queue full");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (occ_ff == 2'd0 && !rd_pend_ff))
      else $error("output words pending while loading");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (count_ff != '0))
      else $error("empty set reached offset stage");

endmodule

// ===== bench/tb_point_set_bbox_centring.sv =====
// Testbench: directed and random point sets through bbox centring, checked word by word
`timescale 1ns / 1ps
module tb_point_set_bbox_centring;
   import pbc_pkg::*;

   localparam int HOLD  = 64;
   localparam int N_DIR = 17;
   localparam int IDLE_PCT  [4] = '{0, 47, 0, 25};
   localparam int STALL_PCT [4] = '{0, 0, 47, 25};

   typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EXTREME} spread_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
      logic      typed;
      coord_type ex;
      coord_type ey;
      logic      el;
   } dir_row_type;

   // a lone point always lands on the centre
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{8'd0,   8'd0,   1'b1, 1'b1, 8'd128, 8'd128, 1'b1},
      '{8'd255, 8'd255, 1'b1, 1'b1, 8'd128, 8'd128, 1'b1},
      '{8'd255, 8'd0,   1'b1, 1'b1, 8'd128, 8'd128, 1'b1},
      '{8'd0,   8'd255, 1'b1, 1'b1, 8'd128, 8'd128, 1'b1},
      '{8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd255, 8'd255, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'hAA,  8'h55,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'h55,  8'hAA,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd128, 8'd128, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd10,  8'd200, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd11,  8'd201, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd12,  8'd199, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd1,   8'd254, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd254, 8'd1,   1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd127, 8'd128, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd0,   8'd255, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{8'd77,  8'd33,  1'b1, 1'b1, 8'd128, 8'd128, 1'b1}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   logic      req_is_last = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_out_x;
   coord_type rsp_out_y;
   logic      rsp_out_last;

   int idle_pct   = 0;
   int stall_pct  = 0;
   int mismatches = 0;

   coord_type    held_x [HOLD];
   coord_type    held_y [HOLD];
   int           held_n = 0;
   coord_type    lo_x = 8'd255, hi_x = 8'd0, lo_y = 8'd255, hi_y = 8'd0;
   rsp_word_type fresh_q   [$];
   rsp_word_type centred_q [$];

   point_set_bbox_centring dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_last (rsp_out_last)
   );

   always #6 clock = ~clock;

   function automatic coord_type centre_clamp(coord_type p, coord_type lo, coord_type hi);
      int v;
      v = int'(p) + 128 - (int'(lo) + int'(hi)) / 2;
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return coord_type'(v);
   endfunction

   // points past a full store are dropped, but a last flag still fires the replay
   function automatic void take_point(coord_type x, coord_type y, logic last);
      rsp_word_type w;
      if (held_n < HOLD) begin
         held_x[held_n] = x;
         held_y[held_n] = y;
         held_n++;
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
      end
      if (last) begin
         for (int k = 0; k < held_n; k++) begin
            w.x    = centre_clamp(held_x[k], lo_x, hi_x);
            w.y    = centre_clamp(held_y[k], lo_y, hi_y);
            w.last = (k == held_n - 1);
            fresh_q.push_back(w);
         end
         held_n = 0;
         lo_x   = 8'd255;
         hi_x   = 8'd0;
         lo_y   = 8'd255;
         hi_y   = 8'd0;
      end
   endfunction

   function automatic coord_type pick_coord(spread_type mode, int base, int span);
      int v;
      case (mode)
         SPREAD_WIDE:    v = $urandom_range(255);
         SPREAD_CLUSTER: v = base + $urandom_range(span);
         default: begin
            case ($urandom_range(3))
               0:       v = 0;
               1:       v = 255;
               default: v = $urandom_range(255);
            endcase
         end
      endcase
      if (v > 255) v = 255;
      return coord_type'(v);
   endfunction

   task automatic send_point(coord_type x, coord_type y, logic last, logic typed,
                             rsp_word_type typed_w);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      take_point(x, y, last);
      if (typed) begin
         fresh_q.delete();
         centred_q.push_back(typed_w);
      end else begin
         while (fresh_q.size() != 0) centred_q.push_back(fresh_q.pop_front());
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (centred_q.size() == 0) begin
            $error("unexpected word: out_x=%0d out_y=%0d out_last=%0b",
                   rsp_out_x, rsp_out_y, rsp_out_last);
            mismatches++;
         end else begin
            want = centred_q.pop_front();
            if (rsp_out_x !== want.x) begin
               $error("out_x: expected %0d, got %0d", want.x, rsp_out_x);
               mismatches++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y: expected %0d, got %0d", want.y, rsp_out_y);
               mismatches++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** point_set_bbox_centring: FAILED **");
      $finish;
   end

   initial begin
      rsp_word_type w;
      spread_type   mode;
      int           sent, n, r, bx, by, span;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         w.x    = DIR_ROWS[i].ex;
         w.y    = DIR_ROWS[i].ey;
         w.last = DIR_ROWS[i].el;
         send_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].last, DIR_ROWS[i].typed, w);
      end

      w = '0;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         sent      = 0;
         while (sent < 125) begin
            r = $urandom_range(9);
            if (r == 0) n = $urandom_range(67, 64);        // fills or overfills the store
            else if (r < 3) n = $urandom_range(63, 17);
            else n = $urandom_range(16, 1);
            mode = spread_type'($urandom_range(2));
            bx   = $urandom_range(255);
            by   = $urandom_range(255);
            span = $urandom_range(63);
            for (int k = 0; k < n; k++) begin
               send_point(pick_coord(mode, bx, span), pick_coord(mode, by, span),
                          k == n - 1, 1'b0, w);
            end
            sent += n;
         end
      end

      req_valid <= 1'b0;
      while (centred_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("** point_set_bbox_centring: PASSED **");
      end else begin
         $display("** point_set_bbox_centring: FAILED **");
      end
      $finish;
   end

endmodule
